>>> hw/rtl/ipv_pkg.sv
package ipv_pkg;

  localparam int unsigned CharW     = 8;
  localparam int unsigned VerdictW  = 2;
  localparam int unsigned DotW      = 3;
  localparam int unsigned ColonW    = 4;
  localparam int unsigned GrpValW   = 9;
  localparam int unsigned GrpLenW   = 3;
  localparam int unsigned ProdW     = 12;

  localparam logic [CharW-1:0]   CharDot    = 8'h2e;
  localparam logic [CharW-1:0]   CharColon  = 8'h3a;
  localparam logic [CharW-1:0]   CharZero   = 8'h30;
  localparam logic [CharW-1:0]   CharNine   = 8'h39;
  localparam logic [CharW-1:0]   CharLowA   = 8'h61;
  localparam logic [CharW-1:0]   CharLowF   = 8'h66;
  localparam logic [CharW-1:0]   CharUpA    = 8'h41;
  localparam logic [CharW-1:0]   CharUpF    = 8'h46;

  localparam logic [GrpValW-1:0] V4GroupMax = 9'd255;
  localparam logic [GrpValW-1:0] ValueSat   = 9'd256;
  localparam logic [GrpLenW-1:0] LengthSat  = 3'd5;
  localparam logic [GrpLenW-1:0] V6GroupMax = 3'd4;
  localparam logic [DotW-1:0]    V4Dots     = 3'd3;
  localparam logic [DotW-1:0]    DotSat     = 3'd7;
  localparam logic [ColonW-1:0]  V6Colons   = 4'd7;
  localparam logic [ColonW-1:0]  ColonSat   = 4'd15;

  typedef enum logic [VerdictW-1:0] {
    VERDICT_NONE = 2'd0,
    VERDICT_IPV4 = 2'd1,
    VERDICT_IPV6 = 2'd2
  } verdict_e;

  typedef struct packed {
    logic       is_dot;
    logic       is_colon;
    logic       is_dig;
    logic       is_hex;
    logic       is_zero;
    logic [3:0] digit;
  } char_class_t;

  function automatic logic v4_group_ok(logic [GrpLenW-1:0] len,
                                       logic [GrpValW-1:0] val,
                                       logic               starts_zero);
    return (len != '0) && (val <= V4GroupMax) && !(starts_zero && (len > 3'd1));
  endfunction

  function automatic logic v6_group_ok(logic [GrpLenW-1:0] len);
    return (len != '0) && (len <= V6GroupMax);
  endfunction

endpackage

>>> hw/rtl/ipv_char_class.sv
module ipv_char_class (
  input  logic [ipv_pkg::CharW-1:0] char_i,
  output ipv_pkg::char_class_t      class_o
);

  logic is_dig;
  logic is_alpha_hex;

  assign is_dig       = (char_i >= ipv_pkg::CharZero) && (char_i <= ipv_pkg::CharNine);
  assign is_alpha_hex = ((char_i >= ipv_pkg::CharLowA) && (char_i <= ipv_pkg::CharLowF)) ||
                        ((char_i >= ipv_pkg::CharUpA)  && (char_i <= ipv_pkg::CharUpF));

  always_comb begin
    class_o          = '0;
    class_o.is_dot   = (char_i == ipv_pkg::CharDot);
    class_o.is_colon = (char_i == ipv_pkg::CharColon);
    class_o.is_dig   = is_dig;
    class_o.is_hex   = is_dig || is_alpha_hex;
    class_o.is_zero  = (char_i == ipv_pkg::CharZero);
    class_o.digit    = char_i[3:0];
  end

endmodule

>>> hw/rtl/ipv_track.sv
module ipv_track (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 fire_i,
  input  logic                 last_i,
  input  ipv_pkg::char_class_t class_i,
  output ipv_pkg::verdict_e    verdict_o
);

  logic [ipv_pkg::DotW-1:0]    dot_cnt_q, dot_cnt_d;
  logic [ipv_pkg::ColonW-1:0]  colon_cnt_q, colon_cnt_d;
  logic                        v4_ok_q, v4_ok_d;
  logic                        v6_ok_q, v6_ok_d;
  logic [ipv_pkg::GrpValW-1:0] grp_val_q, grp_val_d;
  logic [ipv_pkg::GrpLenW-1:0] grp_len_q, grp_len_d;
  logic                        grp_zero_q, grp_zero_d;
  logic [ipv_pkg::ProdW-1:0]   val_times10;
  logic                        v4_final;
  logic                        v6_final;

  // value * 10 + digit, as two shifts and adds
  assign val_times10 = {grp_val_q, 3'b000} + {2'b00, grp_val_q, 1'b0} +
                       {8'b0, class_i.digit};

  always_comb begin
    dot_cnt_d   = dot_cnt_q;
    colon_cnt_d = colon_cnt_q;
    v4_ok_d     = v4_ok_q;
    v6_ok_d     = v6_ok_q;
    grp_val_d   = grp_val_q;
    grp_len_d   = grp_len_q;
    grp_zero_d  = grp_zero_q;
    priority if (class_i.is_dot) begin
      v4_ok_d    = v4_ok_q && ipv_pkg::v4_group_ok(grp_len_q, grp_val_q, grp_zero_q);
      v6_ok_d    = 1'b0;
      if (dot_cnt_q < ipv_pkg::DotSat) dot_cnt_d = dot_cnt_q + 3'd1;
      grp_val_d  = '0;
      grp_len_d  = '0;
      grp_zero_d = 1'b0;
    end else if (class_i.is_colon) begin
      v6_ok_d    = v6_ok_q && ipv_pkg::v6_group_ok(grp_len_q);
      v4_ok_d    = 1'b0;
      if (colon_cnt_q < ipv_pkg::ColonSat) colon_cnt_d = colon_cnt_q + 4'd1;
      grp_val_d  = '0;
      grp_len_d  = '0;
      grp_zero_d = 1'b0;
    end else begin
      v4_ok_d = v4_ok_q && class_i.is_dig;
      v6_ok_d = v6_ok_q && class_i.is_hex;
      if (grp_len_q == '0) grp_zero_d = class_i.is_zero;
      if (grp_len_q < ipv_pkg::LengthSat) grp_len_d = grp_len_q + 3'd1;
      if (class_i.is_dig) begin
        grp_val_d = (val_times10 > {3'b000, ipv_pkg::ValueSat}) ? ipv_pkg::ValueSat
                                                                 : val_times10[8:0];
      end
    end
  end

  // verdict is taken from the state as it stands after this character
  assign v4_final = v4_ok_d && ipv_pkg::v4_group_ok(grp_len_d, grp_val_d, grp_zero_d) &&
                    (dot_cnt_d == ipv_pkg::V4Dots);
  assign v6_final = v6_ok_d && ipv_pkg::v6_group_ok(grp_len_d) &&
                    (colon_cnt_d == ipv_pkg::V6Colons);

  always_comb begin
    priority if (v4_final) begin
      verdict_o = ipv_pkg::VERDICT_IPV4;
    end else if (v6_final) begin
      verdict_o = ipv_pkg::VERDICT_IPV6;
    end else begin
      verdict_o = ipv_pkg::VERDICT_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dot_cnt_q   <= '0;
      colon_cnt_q <= '0;
      v4_ok_q     <= 1'b1;
      v6_ok_q     <= 1'b1;
      grp_val_q   <= '0;
      grp_len_q   <= '0;
      grp_zero_q  <= 1'b0;
    end else if (fire_i) begin
      if (last_i) begin
        dot_cnt_q   <= '0;
        colon_cnt_q <= '0;
        v4_ok_q     <= 1'b1;
        v6_ok_q     <= 1'b1;
        grp_val_q   <= '0;
        grp_len_q   <= '0;
        grp_zero_q  <= 1'b0;
      end else begin
        dot_cnt_q   <= dot_cnt_d;
        colon_cnt_q <= colon_cnt_d;
        v4_ok_q     <= v4_ok_d;
        v6_ok_q     <= v6_ok_d;
        grp_val_q   <= grp_val_d;
        grp_len_q   <= grp_len_d;
        grp_zero_q  <= grp_zero_d;
      end
    end
  end

endmodule

>>> hw/rtl/ip_address_text_validator_core.sv
// Classifies an address string fed one character per item (is_last_i marks the final
// character) as IPv4 dotted decimal, IPv6 eight-group colon hex, or neither. One item is
// taken every cycle while no last character is held back; only the last character of a
// string produces a result item. Its verdict_o is registered: the character sits in the
// input register, then its verdict is loaded into the result register once that is free.
// Non-last characters never wait on the output side; a last character waits only while
// the result register holds an untaken verdict.
module ip_address_text_validator_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] char_code_i,
  input  logic       is_last_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] verdict_o
);

  logic                      in_valid_q;
  logic [ipv_pkg::CharW-1:0] char_q;
  logic                      last_q;
  logic                      out_free;
  logic                      fire;
  logic                      out_valid_q;
  ipv_pkg::verdict_e         verdict_q;
  ipv_pkg::verdict_e         verdict_d;
  ipv_pkg::char_class_t      char_class;

  assign out_free   = !out_valid_q || out_ready_i;
  // a non-last item updates state only, so it moves on even when the output is full
  assign fire       = in_valid_q && (!last_q || out_free);
  assign in_ready_o = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      char_q <= char_code_i;
      last_q <= is_last_i;
    end
  end

  ipv_char_class u_class (
    .char_i  (char_q),
    .class_o (char_class)
  );

  ipv_track u_track (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (fire),
    .last_i    (last_q),
    .class_i   (char_class),
    .verdict_o (verdict_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= fire && last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && fire && last_q) begin
      verdict_q <= verdict_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign verdict_o   = verdict_q;

endmodule

>>> hw/rtl/ipv_checker.sv
module ipv_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [1:0] verdict_o
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(verdict_o))
    else $error("result changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (verdict_o != 2'd3))
    else $error("undefined verdict code");

  // input side is never blocked while the result register can move
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ready_i || !out_valid_o) |-> in_ready_o)
    else $error("input stalled with free output");

  // no result can exist the cycle after reset releases
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> !out_valid_o)
    else $error("result right after reset");

endmodule

bind ip_address_text_validator_core ipv_checker u_ipv_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .verdict_o   (verdict_o)
);

>>> verif/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned StallLimit  = 4000;
  localparam int unsigned RandomChars = 580;
  localparam int unsigned RandomTexts = 30;
  localparam int unsigned ReportMax   = 10;

  // tracks both address hypotheses and holds the verdicts still owed by the block
  class verdict_board;
    logic [ipv_pkg::DotW-1:0]    dots;
    logic [ipv_pkg::ColonW-1:0]  colons;
    bit                          v4_alive;
    bit                          v6_alive;
    logic [ipv_pkg::GrpValW-1:0] grp_val;
    logic [ipv_pkg::GrpLenW-1:0] grp_len;
    bit                          grp_zero;
    ipv_pkg::verdict_e           pending[$];
    int unsigned                 failures;

    function new();
      failures = 0;
      clear_text();
    endfunction

    function void clear_group();
      grp_val  = '0;
      grp_len  = '0;
      grp_zero = 1'b0;
    endfunction

    function void clear_text();
      dots     = '0;
      colons   = '0;
      v4_alive = 1'b1;
      v6_alive = 1'b1;
      clear_group();
    endfunction

    function bit dec_group_fits();
      if (grp_len == 0) return 1'b0;
      if (grp_val > ipv_pkg::V4GroupMax) return 1'b0;
      return !(grp_zero && grp_len != 1);
    endfunction

    function bit hex_group_fits();
      return grp_len >= 1 && grp_len <= ipv_pkg::V6GroupMax;
    endfunction

    function void note_char(logic [ipv_pkg::CharW-1:0] c, logic last);
      bit          dig;
      bit          hex;
      bit          v4;
      bit          v6;
      int unsigned acc;
      dig = c >= ipv_pkg::CharZero && c <= ipv_pkg::CharNine;
      hex = dig || (c >= ipv_pkg::CharLowA && c <= ipv_pkg::CharLowF) ||
            (c >= ipv_pkg::CharUpA && c <= ipv_pkg::CharUpF);
      if (c == ipv_pkg::CharDot) begin
        if (!dec_group_fits()) v4_alive = 1'b0;
        v6_alive = 1'b0;
        if (dots < ipv_pkg::DotSat) dots = dots + 1'b1;
        clear_group();
      end else if (c == ipv_pkg::CharColon) begin
        if (!hex_group_fits()) v6_alive = 1'b0;
        v4_alive = 1'b0;
        if (colons < ipv_pkg::ColonSat) colons = colons + 1'b1;
        clear_group();
      end else begin
        if (!dig) v4_alive = 1'b0;
        if (!hex) v6_alive = 1'b0;
        if (grp_len == 0) grp_zero = (c == ipv_pkg::CharZero);
        if (grp_len < ipv_pkg::LengthSat) grp_len = grp_len + 1'b1;
        if (dig) begin
          acc = grp_val * 10 + (c - ipv_pkg::CharZero);
          grp_val = (acc > ipv_pkg::ValueSat) ? ipv_pkg::ValueSat
                                              : acc[ipv_pkg::GrpValW-1:0];
        end
      end
      if (last) begin
        v4 = v4_alive && dec_group_fits() && dots == ipv_pkg::V4Dots;
        v6 = v6_alive && hex_group_fits() && colons == ipv_pkg::V6Colons;
        pending.push_back(v4 ? ipv_pkg::VERDICT_IPV4 :
                          (v6 ? ipv_pkg::VERDICT_IPV6 : ipv_pkg::VERDICT_NONE));
        clear_text();
      end
    endfunction

    function void check_verdict(logic [ipv_pkg::VerdictW-1:0] got);
      ipv_pkg::verdict_e want;
      if (pending.size() == 0) begin
        if (failures < ReportMax) $display("verdict %0d arrived with no string pending", got);
        failures++;
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        if (failures < ReportMax)
          $display("verdict mismatch: expected %0d, got %0d", want, got);
        failures++;
      end
    endfunction

    function bit clean();
      return failures == 0 && pending.size() == 0;
    endfunction
  endclass

  logic                         clk_i       = 1'b0;
  logic                         rst_ni      = 1'b0;
  logic                         in_valid_i  = 1'b0;
  logic                         in_ready_o;
  logic [ipv_pkg::CharW-1:0]    char_code_i = '0;
  logic                         is_last_i   = 1'b0;
  logic                         out_valid_o;
  logic                         out_ready_i = 1'b0;
  logic [ipv_pkg::VerdictW-1:0] verdict_o;

  verdict_board              board;
  bit                        quiet = 1'b0;
  int unsigned               chars_sent = 0;
  logic [ipv_pkg::CharW-1:0] text_q[$];

  ip_address_text_validator_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .char_code_i (char_code_i),
    .is_last_i   (is_last_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .verdict_o   (verdict_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    forever begin
      @(posedge clk_i);
      out_ready_i <= quiet ? 1'b1 : ($urandom_range(99) >= 33);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) board.check_verdict(verdict_o);
  end

  // counts cycles in which neither channel moves an item
  initial begin
    int unsigned dead_cycles;
    dead_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) dead_cycles = 0;
      else dead_cycles++;
      if (dead_cycles >= StallLimit) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  task automatic send_char(input logic [ipv_pkg::CharW-1:0] c, input logic last);
    while (!quiet && $urandom_range(99) < 33) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    char_code_i <= c;
    is_last_i   <= last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    board.note_char(c, last);
    chars_sent++;
  endtask

  task automatic send_queue();
    for (int i = 0; i < text_q.size(); i++) send_char(text_q[i], i == text_q.size() - 1);
  endtask

  function automatic void push_str(input string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endfunction

  task automatic send_text(input string s);
    text_q.delete();
    push_str(s);
    send_queue();
  endtask

  // mostly well-formed addresses with random content, some noise and damage
  function automatic void build_text();
    string       hex_pool;
    int unsigned kind;
    int unsigned pick;
    int unsigned len;
    int unsigned pos;
    hex_pool = "0123456789abcdefABCDEF";
    text_q.delete();
    kind = $urandom_range(99);
    if (kind < 45) begin
      for (int g = 0; g < 4; g++) begin
        if (g > 0) text_q.push_back(ipv_pkg::CharDot);
        pick = $urandom_range(19);
        if (pick == 3) text_q.push_back(ipv_pkg::CharZero);
        if (pick == 0) push_str("0");
        else if (pick == 1) push_str("255");
        else if (pick == 2) push_str($sformatf("%0d", $urandom_range(256, 999)));
        else if (pick != 4) push_str($sformatf("%0d", $urandom_range(255)));
      end
    end else if (kind < 85) begin
      for (int g = 0; g < 8; g++) begin
        if (g > 0) text_q.push_back(ipv_pkg::CharColon);
        pick = $urandom_range(19);
        len = (pick == 0) ? 0 : (pick == 1) ? $urandom_range(5, 6) : $urandom_range(1, 4);
        for (int d = 0; d < len; d++)
          text_q.push_back(hex_pool[$urandom_range(hex_pool.len() - 1)]);
      end
    end else begin
      len = $urandom_range(1, 30);
      for (int i = 0; i < len; i++) begin
        case ($urandom_range(3))
          0:       text_q.push_back(8'($urandom_range(255)));
          1:       text_q.push_back(ipv_pkg::CharDot);
          2:       text_q.push_back(ipv_pkg::CharColon);
          default: text_q.push_back(hex_pool[$urandom_range(hex_pool.len() - 1)]);
        endcase
      end
    end
    if (kind < 85 && $urandom_range(99) < 20) begin
      pos = $urandom_range(text_q.size() - 1);
      case ($urandom_range(3))
        0:       text_q[pos] = 8'($urandom_range(255));
        1:       text_q.delete(pos);
        2:       text_q.insert(pos, $urandom_range(1) ? ipv_pkg::CharDot : ipv_pkg::CharColon);
        default: text_q.insert(pos, text_q[pos]);
      endcase
    end
    if (text_q.size() == 0) text_q.push_back(ipv_pkg::CharZero);
  endfunction

  initial begin
    int unsigned texts_sent;
    board = new();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_text("0.0.0.0");
    send_text("255.255.255.255");
    send_text("256.0.0.1");
    send_text("00.1.2.3");
    send_text("1..2.3");
    send_text(".1.2.3");
    send_text("1.2.3.");
    send_text("1.2.3.4.5");
    send_text("1:2:3:4:5:6:7:8");
    send_text("abcd:EF01:0:ffff:A:b:C:dEf9");
    send_text("12345:0:0:0:0:0:0:0");
    send_text("::1:2:3:4:5:6");
    send_text("1:2:3:4:5:6:7:");
    send_text("1.2:3.4");
    send_text("0");
    send_text("g");
    text_q.delete();
    text_q.push_back(8'hff);
    text_q.push_back(8'h80);
    text_q.push_back(8'h00);
    send_queue();
    // long run without a last flag so every counter saturates
    for (int i = 0; i < 9; i++) send_char(ipv_pkg::CharDot, 1'b0);
    for (int i = 0; i < 17; i++) send_char(ipv_pkg::CharColon, 1'b0);
    send_text("99999991");

    chars_sent = 0;
    texts_sent = 0;
    while (chars_sent < RandomChars || texts_sent < RandomTexts) begin
      quiet = (texts_sent >= 15 && texts_sent < 25);
      if (texts_sent == 8) begin
        in_valid_i <= 1'b0;
        while (board.pending.size() != 0) @(posedge clk_i);
      end
      build_text();
      send_queue();
      texts_sent++;
    end

    quiet = 1'b0;
    in_valid_i <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (board.clean()) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/ipv_pkg.sv
hw/rtl/ipv_char_class.sv
hw/rtl/ipv_track.sv
hw/rtl/ip_address_text_validator_core.sv
hw/rtl/ipv_checker.sv
verif/tb.sv
